@@ hdl/qsp_pkg.sv @@
package qsp_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned TAG_W  = 2;
   localparam int unsigned HELD_W = 2;

   localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
   localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

   localparam logic [TAG_W-1:0] TAG_NAME  = 2'd0;
   localparam logic [TAG_W-1:0] TAG_VALUE = 2'd1;
   localparam logic [TAG_W-1:0] TAG_END   = 2'd2;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   localparam logic [HELD_W-1:0] HELD_NONE  = 2'd0;
   localparam logic [HELD_W-1:0] HELD_PCT   = 2'd1;
   localparam logic [HELD_W-1:0] HELD_DIGIT = 2'd2;

   localparam int unsigned MAX_RUN   = 3;
   localparam int unsigned RUN_W     = $clog2(MAX_RUN + 1);
   localparam int unsigned RSP_DEPTH = 8;
   localparam int unsigned PTR_W     = $clog2(RSP_DEPTH);
   localparam int unsigned CNT_W     = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] in_char;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic [TAG_W-1:0]  tag;
      logic              pair_ok;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic              in_value;
      logic              name_seen;
      logic [HELD_W-1:0] held_count;
      logic [CHAR_W-1:0] held_digit;
   } state_type;

   function automatic logic is_hex(input logic [CHAR_W-1:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
      end
      hex_val = d[3:0];
   endfunction

endpackage

@@ hdl/qsp_decode.sv @@
module qsp_decode
   import qsp_pkg::*;
(
   input  req_type          req,
   input  state_type        cur,
   output state_type        nxt,
   output logic [RUN_W-1:0] run_n,
   output rsp_type          run [MAX_RUN]
);

   logic [CHAR_W-1:0] c;
   logic              do_plain;
   logic [RUN_W-1:0]  n;

   assign c = req.in_char;

   always_comb begin
      nxt      = cur;
      n        = '0;
      do_plain = 1'b0;
      for (int i = 0; i < MAX_RUN; i++) begin
         run[i] = '0;
      end

      if (req.kind == KIND_EOS || c == CH_AMP) begin
         if (cur.held_count == HELD_PCT || cur.held_count == HELD_DIGIT) begin
            run[n] = '{CH_PCT, TAG_VALUE, 1'b0, 1'b0};
            n = n + 1'b1;
            if (cur.held_count == HELD_DIGIT) begin
               run[n] = '{cur.held_digit, TAG_VALUE, 1'b0, 1'b0};
               n = n + 1'b1;
            end
         end
         run[n] = '{'0, TAG_END, cur.in_value & cur.name_seen, 1'b0};
         n = n + 1'b1;
         nxt.in_value   = 1'b0;
         nxt.name_seen  = 1'b0;
         nxt.held_count = HELD_NONE;
         nxt.held_digit = '0;
      end else if (!cur.in_value) begin
         if (c == CH_EQ) begin
            nxt.in_value = 1'b1;
         end else begin
            run[n] = '{c, TAG_NAME, 1'b0, 1'b0};
            n = n + 1'b1;
            nxt.name_seen = 1'b1;
         end
      end else begin
         case (cur.held_count)
            HELD_PCT: begin
               if (is_hex(c)) begin
                  nxt.held_digit = c;
                  nxt.held_count = HELD_DIGIT;
               end else begin
                  run[n] = '{CH_PCT, TAG_VALUE, 1'b0, 1'b0};
                  n = n + 1'b1;
                  nxt.held_count = HELD_NONE;
                  do_plain = 1'b1;
               end
            end
            HELD_DIGIT: begin
               nxt.held_count = HELD_NONE;
               if (is_hex(c) && !(cur.held_digit == CH_ZERO && c == CH_ZERO)) begin
                  run[n] = '{{hex_val(cur.held_digit), hex_val(c)}, TAG_VALUE, 1'b0, 1'b0};
                  n = n + 1'b1;
               end else begin
                  run[n] = '{CH_PCT, TAG_VALUE, 1'b0, 1'b0};
                  n = n + 1'b1;
                  run[n] = '{cur.held_digit, TAG_VALUE, 1'b0, 1'b0};
                  n = n + 1'b1;
                  if (is_hex(c)) begin
                     run[n] = '{c, TAG_VALUE, 1'b0, 1'b0};
                     n = n + 1'b1;
                  end else begin
                     do_plain = 1'b1;
                  end
               end
            end
            default: begin
               nxt.held_count = HELD_NONE;
               do_plain = 1'b1;
            end
         endcase

         if (do_plain) begin
            if (c == CH_PCT) begin
               nxt.held_count = HELD_PCT;
            end else begin
               run[n] = '{(c == CH_PLUS) ? CH_SPACE : c, TAG_VALUE, 1'b0, 1'b0};
               n = n + 1'b1;
            end
         end
      end

      if (n != '0) begin
         run[n - 1'b1].last_of_run = 1'b1;
      end
      run_n = n;
   end

endmodule

@@ hdl/qsp_fifo.sv @@
module qsp_fifo
   import qsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [RUN_W-1:0] push_n,
   input  rsp_type          push_data [MAX_RUN],
   input  logic             pop,
   output rsp_type          head,
   output logic             not_empty,
   output logic             has_room
);

   rsp_type           mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign not_empty = (count_ff != '0);
   assign has_room  = (count_ff <= CNT_W'(RSP_DEPTH - MAX_RUN));
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RUN; i++) begin
         if (RUN_W'(i) < push_n) begin
            mem_ff[wr_ptr_ff + PTR_W'(i)] <= push_data[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/query_string_pair_splitter_decoder.sv @@
// Query string splitter with form decoding of values.
//
// req channel: one word per query character (kind 0) or end of string
// (kind 1). rsp channel: name bytes, decoded value bytes and one pair-end
// word per '&'-separated segment; last_of_run marks the final word that a
// request word produced.
//
// A request word is decoded in the cycle it is accepted and its zero to
// three result words are written into an 8-entry registered result queue;
// the first shows on rsp once any words ahead of it have gone. The queue
// takes a new request whenever it has room for three words, so a request
// is taken every cycle while the output keeps up; when rsp_stall is low
// rsp drains one word per cycle, the sustained rate for bad-escape values.
//
// Reset empties the queue and returns the parser to the name of a fresh
// segment. While rsp_stall is high the head word holds, and req_stall rises
// once fewer than three queue entries are free.
module query_string_pair_splitter_decoder
   import qsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type        state_ff;
   state_type        state_in;
   logic [RUN_W-1:0] run_n;
   logic [RUN_W-1:0] push_n;
   rsp_type          run [MAX_RUN];
   logic             has_room;
   logic             accept;

   assign req_stall = !has_room;
   assign accept    = req_valid && has_room;
   assign push_n    = accept ? run_n : '0;

   qsp_decode u_decode (
      .req   (req_data),
      .cur   (state_ff),
      .nxt   (state_in),
      .run_n (run_n),
      .run   (run)
   );

   qsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_data (run),
      .pop       (rsp_valid && !rsp_stall),
      .head      (rsp_data),
      .not_empty (rsp_valid),
      .has_room  (has_room)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/qsp_checker.sv @@
module qsp_checker
   import qsp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word changed");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tag == TAG_END |-> rsp_data.out_char == '0 &&
      rsp_data.last_of_run)
      else $error("pair-end word malformed");

   a_eos_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == KIND_EOS |=> rsp_valid)
      else $error("end of string gave no result");

endmodule

bind query_string_pair_splitter_decoder qsp_checker u_qsp_checker (.*);

@@ tb/query_string_pair_splitter_decoder_tb.sv @@
module query_string_pair_splitter_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qsp_pkg::*;

   typedef struct {
      req_type word;
      bit      drain_first;
   } query_word_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   query_word_type pending[$];
   rsp_type     results_due[$];
   bit          pause_next = 1'b0;
   bit          req_took = 1'b0;
   bit          held_long = 1'b0;
   int unsigned hold_left = 0;
   int unsigned words_queued = 0;
   int unsigned words_in = 0;
   int unsigned words_out = 0;
   int unsigned pairs_closed = 0;
   int unsigned pairs_ok = 0;
   int unsigned mismatches = 0;

   logic              val_mode = 1'b0;
   logic              got_name = 1'b0;
   logic [HELD_W-1:0] held_n = HELD_NONE;
   logic [CHAR_W-1:0] held_ch = '0;
   rsp_type           run_buf[0:MAX_RUN-1];
   int                run_len = 0;

   query_string_pair_splitter_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic [4:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = '0;
      digit_of = 5'h00;
      if (c >= "0" && c <= "9") begin
         d = c - "0";
         digit_of = {1'b1, d[3:0]};
      end else if (c >= "A" && c <= "F") begin
         d = c - "A" + 8'd10;
         digit_of = {1'b1, d[3:0]};
      end else if (c >= "a" && c <= "f") begin
         d = c - "a" + 8'd10;
         digit_of = {1'b1, d[3:0]};
      end
   endfunction

   function automatic void put_byte(input logic [CHAR_W-1:0] c, input logic [TAG_W-1:0] t,
                                    input logic ok);
      if (run_len < MAX_RUN) begin
         run_buf[run_len] = {c, t, ok, 1'b0};
         run_len++;
      end
   endfunction

   function automatic void spill_held();
      if (held_n == HELD_PCT || held_n == HELD_DIGIT) begin
         put_byte(CH_PCT, TAG_VALUE, 1'b0);
         if (held_n == HELD_DIGIT) put_byte(held_ch, TAG_VALUE, 1'b0);
      end
      held_n = HELD_NONE;
      held_ch = '0;
   endfunction

   function automatic void plain_value(input logic [CHAR_W-1:0] c);
      if (c == CH_PCT) begin
         held_n = HELD_PCT;
      end else begin
         put_byte((c == CH_PLUS) ? CH_SPACE : c, TAG_VALUE, 1'b0);
      end
   endfunction

   function automatic void close_segment();
      spill_held();
      put_byte('0, TAG_END, val_mode & got_name);
      val_mode = 1'b0;
      got_name = 1'b0;
   endfunction

   function automatic void decode_word(input req_type w);
      logic [CHAR_W-1:0] c;
      logic [4:0]        hi;
      logic [4:0]        lo;
      rsp_type           r;
      c = w.in_char;
      run_len = 0;
      if (w.kind == KIND_EOS || c == CH_AMP) begin
         close_segment();
      end else if (!val_mode) begin
         if (c == CH_EQ) begin
            val_mode = 1'b1;
         end else begin
            put_byte(c, TAG_NAME, 1'b0);
            got_name = 1'b1;
         end
      end else if (held_n == HELD_PCT) begin
         if (digit_of(c) >= 5'h10) begin
            held_ch = c;
            held_n = HELD_DIGIT;
         end else begin
            spill_held();
            plain_value(c);
         end
      end else if (held_n == HELD_DIGIT) begin
         hi = digit_of(held_ch);
         lo = digit_of(c);
         if (lo[4]) begin
            if ({hi[3:0], lo[3:0]} == 8'h00) begin
               spill_held();
               put_byte(c, TAG_VALUE, 1'b0);
            end else begin
               put_byte({hi[3:0], lo[3:0]}, TAG_VALUE, 1'b0);
               held_n = HELD_NONE;
               held_ch = '0;
            end
         end else begin
            spill_held();
            plain_value(c);
         end
      end else begin
         held_n = HELD_NONE;
         plain_value(c);
      end
      for (int i = 0; i < run_len; i++) begin
         r = run_buf[i];
         r.last_of_run = (i == run_len - 1);
         results_due.push_back(r);
      end
   endfunction

   function automatic int send_gap_pct();
      if (words_in < 45) return 37;
      if (words_in < 90) return 51;
      return 0;
   endfunction

   function automatic int recv_gap_pct();
      if (words_in < 45) return 51;
      if (words_in < 90) return 37;
      return 0;
   endfunction

   function automatic void add_word(input logic kind, input logic [CHAR_W-1:0] c);
      query_word_type w;
      w.word.kind = kind;
      w.word.in_char = c;
      w.drain_first = pause_next;
      pause_next = 1'b0;
      pending.push_back(w);
      words_queued++;
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_word(KIND_CHAR, s[i]);
   endfunction

   function automatic logic [CHAR_W-1:0] name_char();
      if ($urandom_range(3) != 0) return 8'(8'h61 + $urandom_range(25));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(21)];
   endfunction

   function automatic void add_segment();
      int n;
      n = $urandom_range(4);
      for (int k = 0; k < n; k++) add_word(KIND_CHAR, name_char());
      if ($urandom_range(9) != 0) add_word(KIND_CHAR, CH_EQ);
      n = $urandom_range(6);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(11))
            0, 1, 2, 3: add_word(KIND_CHAR, name_char());
            4: add_word(KIND_CHAR, CH_PLUS);
            5: add_word(KIND_CHAR, CH_EQ);
            6, 7: begin
               add_word(KIND_CHAR, CH_PCT);
               add_word(KIND_CHAR, hex_char());
               add_word(KIND_CHAR, hex_char());
            end
            8: begin
               add_word(KIND_CHAR, CH_PCT);
               add_word(KIND_CHAR, CH_ZERO);
               add_word(KIND_CHAR, CH_ZERO);
            end
            9: begin
               add_word(KIND_CHAR, CH_PCT);
               add_word(KIND_CHAR, hex_char());
               add_word(KIND_CHAR, 8'($urandom_range(255)));
            end
            10: add_word(KIND_CHAR, CH_PCT);
            default: add_word(KIND_CHAR, 8'($urandom_range(255)));
         endcase
      end
      if ($urandom_range(7) == 0) begin
         add_word(KIND_EOS, 8'($urandom_range(255)));
      end else begin
         add_word(KIND_CHAR, CH_AMP);
      end
   endfunction

   always @(negedge clock) begin
      logic        go;
      query_word_type next_word;
      go = 1'b0;
      if (!reset && (!req_valid || req_took)) begin
         if (pending.size() != 0 && !(pending[0].drain_first && results_due.size() != 0)
             && $urandom_range(99) >= send_gap_pct()) begin
            next_word = pending.pop_front();
            req_data <= next_word.word;
            go = 1'b1;
         end
         req_valid <= go;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!held_long && words_in >= 100) begin
            held_long = 1'b1;
            hold_left = 49;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_gap_pct());
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            words_in++;
            decode_word(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: result word %h with nothing expected", $time, rsp_data);
            end else begin
               want = results_due.pop_front();
               words_out++;
               if (rsp_data.out_char !== want.out_char || rsp_data.tag !== want.tag ||
                   rsp_data.pair_ok !== want.pair_ok ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  mismatches++;
                  $display("%0t: expected char %h tag %0d ok %b last %b, got char %h tag %0d ok %b last %b",
                           $time, want.out_char, want.tag, want.pair_ok, want.last_of_run,
                           rsp_data.out_char, rsp_data.tag, rsp_data.pair_ok,
                           rsp_data.last_of_run);
               end
               if (want.tag == TAG_END) begin
                  pairs_closed++;
                  if (want.pair_ok) pairs_ok++;
               end
            end
         end
      end
   end

   initial begin
      int unsigned base;
      add_word(KIND_CHAR, 8'h00);
      add_word(KIND_CHAR, 8'hFF);
      add_text("=+");
      add_word(KIND_CHAR, 8'hFF);
      add_text("%41%00%%4g");
      add_text("=%a&");
      add_text("=x&");
      add_text("n");
      add_word(KIND_EOS, 8'hFF);
      add_text("&");
      add_text("k=%");
      add_word(KIND_EOS, 8'h00);
      pause_next = 1'b1;
      base = words_queued;
      while (words_queued - base < 95) begin
         if ($urandom_range(9) == 0) begin
            add_word(logic'($urandom_range(3) == 0), 8'($urandom_range(255)));
         end else begin
            add_segment();
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid) @(negedge clock);
      while (results_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("covered %0d request words and %0d result words: %0d segments closed, %0d accepted",
               words_in, words_out, pairs_closed, pairs_ok);
      if (mismatches == 0) begin
         $display("query_string_pair_splitter_decoder_tb: clean");
      end else begin
         $display("query_string_pair_splitter_decoder_tb: errors");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("query_string_pair_splitter_decoder_tb: errors");
      $finish;
   end

endmodule
